>>> rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int KEY_W     = 14;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 7;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_KEY = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET         = 7'd64;
  localparam logic [KEY_W-1:0] LARGEST_KEY_RESET = 14'd10000;
  localparam logic [CAP_W-1:0] CAP_MAX           = CAP_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_END           = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX          = IDX_W'(ENTRIES - 1);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic plan;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic reject_now;
    logic pass_done;
    logic need_update;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative 64-entry key-value cache with least-recently-used
// replacement. A request (get or put) is taken when start is high and busy
// is low; its single result appears on the out_ ports for one cycle, marked
// by out_strobe, in the first cycle in which busy is low, and must be taken
// then. Each request whose key is not rejected sweeps the rank, key and
// value memories one entry per cycle through their single read port. A
// rejected key skips the sweep, a get miss (or a put that finds no slot)
// makes one pass, and a hit or an insert makes two, since the rank memory
// is swept a second time to age the entries. No clearing pass is needed
// after reset.
module lru_key_value_cache (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_kind,
  input  wire        [lkvc_pkg::KEY_W-1:0]     in_key,
  input  wire signed [lkvc_pkg::VAL_W-1:0]     in_value,
  input  wire                                cfg_we,
  input  wire        [lkvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [lkvc_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                               out_strobe,
  output logic                               out_found,
  output logic signed [lkvc_pkg::VAL_W-1:0]    out_read_value,
  output logic                               out_rejected
);

  lkvc_pkg::cmd_t    cmd;
  lkvc_pkg::status_t status;

  lkvc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  lkvc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .status         (status),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_rejected   (out_rejected)
  );

endmodule

`default_nettype wire

>>> rtl/core/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  lkvc_pkg::status_t status,
  output lkvc_pkg::cmd_t   cmd
);

  lkvc_pkg::state_t state_r;
  lkvc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != lkvc_pkg::ST_IDLE);
    unique case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = status.reject_now ? lkvc_pkg::ST_EMIT : lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.pass_done) begin
          state_nxt = lkvc_pkg::ST_PLAN;
        end
      end
      lkvc_pkg::ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = status.need_update ? lkvc_pkg::ST_UPDATE : lkvc_pkg::ST_EMIT;
      end
      lkvc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.pass_done) begin
          state_nxt = lkvc_pkg::ST_EMIT;
        end
      end
      lkvc_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/lkvc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_datapath (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_kind,
  input  wire        [lkvc_pkg::KEY_W-1:0]     in_key,
  input  wire signed [lkvc_pkg::VAL_W-1:0]     in_value,
  input  wire                                cfg_we,
  input  wire        [lkvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [lkvc_pkg::CFG_W-1:0]     cfg_wdata,
  input  lkvc_pkg::cmd_t                     cmd,
  output lkvc_pkg::status_t                  status,
  output logic                               out_strobe,
  output logic                               out_found,
  output logic signed [lkvc_pkg::VAL_W-1:0]    out_read_value,
  output logic                               out_rejected
);

  // Configuration registers.
  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  logic [lkvc_pkg::KEY_W-1:0] lkey_r;

  // Captured request.
  logic                       req_kind_r;
  logic [lkvc_pkg::KEY_W-1:0] req_key_r;
  logic [lkvc_pkg::VAL_W-1:0] req_val_r;
  logic                       req_rej_r;

  // Storage.
  logic [lkvc_pkg::KEY_W-1:0] key_mem  [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] val_mem  [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::IDX_W-1:0] rank_mem [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0] valid_r;
  logic [lkvc_pkg::ENTRIES-1:0] valid_nxt;
  logic [lkvc_pkg::CAP_W-1:0]   live_r;
  logic [lkvc_pkg::CAP_W-1:0]   live_nxt;

  // Sweep pipeline: address stage and data stage.
  logic [lkvc_pkg::CNT_W-1:0] cnt_r;
  logic                       issue;
  logic [lkvc_pkg::IDX_W-1:0] rd_addr;
  logic                       rd_vld_r;
  logic [lkvc_pkg::IDX_W-1:0] rd_idx_r;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] val_q;
  logic [lkvc_pkg::IDX_W-1:0] rank_q;
  logic                       entry_live;
  logic                       scan_step;
  logic                       upd_step;

  // Scan results.
  logic                       hit_r;
  logic [lkvc_pkg::IDX_W-1:0] hit_idx_r;
  logic [lkvc_pkg::IDX_W-1:0] hit_rank_r;
  logic [lkvc_pkg::VAL_W-1:0] hit_val_r;
  logic                       vic_found_r;
  logic [lkvc_pkg::IDX_W-1:0] vic_idx_r;
  logic [lkvc_pkg::IDX_W-1:0] vic_rank_r;
  logic                       free_found_r;
  logic [lkvc_pkg::IDX_W-1:0] free_idx_r;

  // Plan.
  logic [lkvc_pkg::CAP_W-1:0] cap_eff;
  logic                       evict;
  logic                       slot_ok;
  logic [lkvc_pkg::IDX_W-1:0] slot;
  logic                       plan_upd_r;
  logic                       plan_evict_r;
  logic [lkvc_pkg::IDX_W-1:0] slot_r;

  // Rank update and commit.
  logic [lkvc_pkg::IDX_W-1:0] tgt_idx;
  logic                       bump;
  logic                       rank_we;
  logic [lkvc_pkg::IDX_W-1:0] rank_wdata;
  logic                       commit;
  logic                       key_we;
  logic                       val_we;
  logic [lkvc_pkg::IDX_W-1:0] val_waddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= lkvc_pkg::CAP_RESET;
      lkey_r <= lkvc_pkg::LARGEST_KEY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lkvc_pkg::CFG_CAPACITY:    cap_r  <= cfg_wdata[lkvc_pkg::CAP_W-1:0];
        lkvc_pkg::CFG_LARGEST_KEY: lkey_r <= cfg_wdata[lkvc_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.reject_now = (in_key > lkey_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_kind_r <= in_kind;
      req_key_r  <= in_key;
      req_val_r  <= in_value;
      req_rej_r  <= status.reject_now;
    end
  end

  // Sweep counter: one entry issued per cycle, its data in the following cycle.
  assign issue   = (cmd.scan || cmd.update) && (cnt_r < lkvc_pkg::CNT_END);
  assign rd_addr = cnt_r[lkvc_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.accept || cmd.plan) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      key_q <= key_mem[rd_addr];
      val_q <= val_mem[rd_addr];
    end
    if (key_we) begin
      key_mem[slot_r] <= req_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= req_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rank_q <= rank_mem[rd_addr];
    end
    if (rank_we) begin
      rank_mem[rd_idx_r] <= rank_wdata;
    end
  end

  assign entry_live       = valid_r[rd_idx_r];
  assign scan_step        = rd_vld_r && cmd.scan;
  assign upd_step         = rd_vld_r && cmd.update;
  assign status.pass_done = rd_vld_r && (rd_idx_r == lkvc_pkg::LAST_IDX);

  // The scan finds the first matching key, the oldest live entry and the
  // first free slot in a single pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.accept) begin
      hit_r        <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (scan_step) begin
      if (!hit_r && entry_live && (key_q == req_key_r)) begin
        hit_r <= 1'b1;
      end
      if (entry_live && (!vic_found_r || (rank_q > vic_rank_r))) begin
        vic_found_r <= 1'b1;
      end
      if (!entry_live && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_step) begin
      if (!hit_r && entry_live && (key_q == req_key_r)) begin
        hit_idx_r  <= rd_idx_r;
        hit_rank_r <= rank_q;
        hit_val_r  <= val_q;
      end
      if (entry_live && (!vic_found_r || (rank_q > vic_rank_r))) begin
        vic_idx_r  <= rd_idx_r;
        vic_rank_r <= rank_q;
      end
      if (!entry_live && !free_found_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = lkvc_pkg::CAP_W'(1);
    end else if (cap_r > lkvc_pkg::CAP_MAX) begin
      cap_eff = lkvc_pkg::CAP_MAX;
    end else begin
      cap_eff = cap_r;
    end
    evict = (live_r >= cap_eff);
    // After an eviction the lowest free index may be the victim itself.
    if (evict) begin
      slot_ok = vic_found_r;
      slot    = (free_found_r && (free_idx_r < vic_idx_r)) ? free_idx_r : vic_idx_r;
    end else begin
      slot_ok = free_found_r;
      slot    = free_idx_r;
    end
  end

  assign status.need_update = !req_rej_r &&
                              (hit_r || ((req_kind_r == lkvc_pkg::KIND_PUT) && slot_ok));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_upd_r <= 1'b0;
    end else if (cmd.accept) begin
      plan_upd_r <= 1'b0;
    end else if (cmd.plan) begin
      plan_upd_r <= status.need_update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      plan_evict_r <= evict;
      slot_r       <= slot;
    end
  end

  // Rank sweep: a hit moves to the front and the entries ahead of it age
  // by one; an insert ages every surviving live entry.
  always_comb begin
    tgt_idx = hit_r ? hit_idx_r : slot_r;
    if (hit_r) begin
      bump = entry_live && (rank_q < hit_rank_r);
    end else begin
      bump = entry_live && !(plan_evict_r && (rd_idx_r == vic_idx_r));
    end
    rank_we    = upd_step && ((rd_idx_r == tgt_idx) || bump);
    rank_wdata = (rd_idx_r == tgt_idx) ? '0 : rank_q + 1'b1;
  end

  assign commit    = cmd.emit && plan_upd_r;
  assign key_we    = commit && !hit_r;
  assign val_we    = commit && (!hit_r || (req_kind_r == lkvc_pkg::KIND_PUT));
  assign val_waddr = hit_r ? hit_idx_r : slot_r;

  always_comb begin
    valid_nxt = valid_r;
    live_nxt  = live_r;
    if (key_we) begin
      if (plan_evict_r) begin
        valid_nxt[vic_idx_r] = 1'b0;
      end else begin
        live_nxt = live_r + 1'b1;
      end
      valid_nxt[slot_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found      <= !req_rej_r && hit_r;
      out_rejected   <= req_rej_r;
      out_read_value <= (!req_rej_r && hit_r && (req_kind_r == lkvc_pkg::KIND_GET)) ?
                        hit_val_r : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lkvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            start,
  input wire                            busy,
  input wire                            out_strobe,
  input wire                            out_found,
  input wire [lkvc_pkg::VAL_W-1:0]        out_read_value,
  input wire                            out_rejected
);

  // An accepted request always raises busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result follows a busy period and appears once the block is free.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of a busy period");

  a_found_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_found && out_rejected))
    else $error("result both found and rejected");

  a_value_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_read_value == '0))
    else $error("nonzero read value without a hit");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_found      (out_found),
  .out_read_value (out_read_value),
  .out_rejected   (out_rejected)
);

`default_nettype wire

>>> tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  localparam int KEY_MAX       = (1 << lkvc_pkg::KEY_W) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 2 * lkvc_pkg::ENTRIES + 8;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic                              found;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;
    logic                              rejected;
  } cache_reply_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t                           op;
    logic [lkvc_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [lkvc_pkg::CFG_W-1:0]        reg_data;
    logic                              kind;
    logic [lkvc_pkg::KEY_W-1:0]        key;
    logic signed [lkvc_pkg::VAL_W-1:0] value;
    logic                              has_reply;
    cache_reply_t                      reply;
  } dir_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_kind = 1'b0;
  logic [lkvc_pkg::KEY_W-1:0]        in_key = '0;
  logic signed [lkvc_pkg::VAL_W-1:0] in_value = '0;
  logic                              cfg_we = 1'b0;
  logic [lkvc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [lkvc_pkg::CFG_W-1:0]        cfg_wdata = '0;
  logic                              out_strobe;
  logic                              out_found;
  logic signed [lkvc_pkg::VAL_W-1:0] out_read_value;
  logic                              out_rejected;

  // Shadow copy of the cache contents and its registers.
  logic [lkvc_pkg::KEY_W-1:0]        shadow_key [lkvc_pkg::ENTRIES];
  logic signed [lkvc_pkg::VAL_W-1:0] shadow_val [lkvc_pkg::ENTRIES];
  bit                                shadow_live [lkvc_pkg::ENTRIES];
  int                                shadow_rank [lkvc_pkg::ENTRIES];
  int                                shadow_count;
  logic [lkvc_pkg::CAP_W-1:0]        shadow_cap;
  logic [lkvc_pkg::KEY_W-1:0]        shadow_largest;

  cache_reply_t pending_replies [$];
  dir_row_t     directed_rows [$];

  int sender_idle_pct = 11;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int n_requests = 0, n_get_hit = 0, n_get_miss = 0, n_put_update = 0;
  int n_put_insert = 0, n_evict = 0, n_rejected = 0;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_rejected   (out_rejected)
  );

  always #4 clk = ~clk;

  // Applies one request to the shadow cache and returns the reply it earns.
  function automatic cache_reply_t predict_access(logic kind, logic [lkvc_pkg::KEY_W-1:0] key,
                                                  logic signed [lkvc_pkg::VAL_W-1:0] value);
    cache_reply_t r;
    int hit, slot, victim, eff_cap, old_rank;
    r = '0;
    if (key > shadow_largest) begin
      r.rejected = 1'b1;
      n_rejected++;
      return r;
    end
    hit = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (hit < 0 && shadow_live[i] && shadow_key[i] == key) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      if (kind == lkvc_pkg::KIND_GET) begin
        r.read_value = shadow_val[hit];
        n_get_hit++;
      end else begin
        shadow_val[hit] = value;
        n_put_update++;
      end
      old_rank = shadow_rank[hit];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (shadow_live[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
      end
      shadow_rank[hit] = 0;
      return r;
    end
    if (kind == lkvc_pkg::KIND_GET) begin
      n_get_miss++;
      return r;
    end
    n_put_insert++;
    eff_cap = shadow_cap;
    if (eff_cap < 1) eff_cap = 1;
    if (eff_cap > lkvc_pkg::ENTRIES) eff_cap = lkvc_pkg::ENTRIES;
    if (shadow_count >= eff_cap) begin
      victim = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (shadow_live[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
          victim = i;
      end
      if (victim >= 0) begin
        shadow_live[victim] = 1'b0;
        shadow_rank[victim] = 0;
        if (shadow_count > 0) shadow_count--;
        n_evict++;
      end
    end
    slot = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (slot < 0 && !shadow_live[i]) slot = i;
    end
    if (slot < 0) return r;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (shadow_live[i]) shadow_rank[i]++;
    end
    shadow_key[slot]  = key;
    shadow_val[slot]  = value;
    shadow_live[slot] = 1'b1;
    shadow_rank[slot] = 0;
    shadow_count++;
    return r;
  endfunction

  function automatic void add_write(logic [lkvc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lkvc_pkg::CFG_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.op = ROW_WRITE;
    row.reg_index = idx;
    row.reg_data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_req(logic kind, logic [lkvc_pkg::KEY_W-1:0] key,
                                  logic signed [lkvc_pkg::VAL_W-1:0] value);
    dir_row_t row;
    row = '0;
    row.op = ROW_REQUEST;
    row.kind = kind;
    row.key = key;
    row.value = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic kind, logic [lkvc_pkg::KEY_W-1:0] key,
                                    logic signed [lkvc_pkg::VAL_W-1:0] value, logic found,
                                    logic signed [lkvc_pkg::VAL_W-1:0] read_value,
                                    logic rejected);
    dir_row_t row;
    row = '0;
    row.op = ROW_REQUEST;
    row.kind = kind;
    row.key = key;
    row.value = value;
    row.has_reply = 1'b1;
    row.reply = '{found, read_value, rejected};
    directed_rows.push_back(row);
  endfunction

  // Holds start low until every outstanding reply has arrived, then idles.
  task automatic drain_replies(int settle);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [lkvc_pkg::CFG_IDX_W-1:0] idx,
                           logic [lkvc_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == lkvc_pkg::CFG_CAPACITY) shadow_cap = data[lkvc_pkg::CAP_W-1:0];
    else shadow_largest = data[lkvc_pkg::KEY_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue_request(logic kind, logic [lkvc_pkg::KEY_W-1:0] key,
                               logic signed [lkvc_pkg::VAL_W-1:0] value, logic use_given,
                               cache_reply_t given);
    int gap;
    cache_reply_t predicted;
    // Gaps reach past the longest busy period of the block's sweep.
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(150, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_access(kind, key, value);
    pending_replies.push_back(use_given ? given : predicted);
    n_requests++;
  endtask

  task automatic run_phase(int n_items, int idle_pct, logic [lkvc_pkg::CAP_W-1:0] cap,
                           logic [lkvc_pkg::KEY_W-1:0] largest, int pool_size);
    int pool [96];
    int roll;
    logic [lkvc_pkg::CFG_W-1:0] cap_word;
    logic kind;
    logic [lkvc_pkg::KEY_W-1:0] key;
    drain_replies(SETTLE_CYCLES);
    // Upper data bits are junk for the capacity register and must be ignored.
    cap_word = lkvc_pkg::CFG_W'($urandom);
    cap_word[lkvc_pkg::CAP_W-1:0] = cap;
    write_reg(lkvc_pkg::CFG_CAPACITY, cap_word);
    write_reg(lkvc_pkg::CFG_LARGEST_KEY, largest);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < pool_size; i++) pool[i] = $urandom_range(int'(largest));
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 8 && int'(largest) != KEY_MAX)
        key = lkvc_pkg::KEY_W'($urandom_range(KEY_MAX, int'(largest) + 1));
      else if (roll < 25)
        key = lkvc_pkg::KEY_W'($urandom);
      else
        key = lkvc_pkg::KEY_W'(pool[$urandom_range(pool_size - 1)]);
      kind = ($urandom_range(99) < 60) ? lkvc_pkg::KIND_PUT : lkvc_pkg::KIND_GET;
      issue_request(kind, key, $urandom, 1'b0, '0);
      if ($urandom_range(39) == 0) drain_replies(0);
    end
  endtask

  always @(posedge clk) begin : reply_check
    cache_reply_t want;
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: reply with no request pending: found=%0b value=%0d rejected=%0b",
                   $time, out_found, out_read_value, out_rejected);
      end else begin
        want = pending_replies.pop_front();
        if (out_found !== want.found || out_read_value !== want.read_value ||
            out_rejected !== want.rejected) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: reply differs: expected found=%0b value=%0d rejected=%0b,",
                      " got found=%0b value=%0d rejected=%0b"},
                     $time, want.found, want.read_value, want.rejected,
                     out_found, out_read_value, out_rejected);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      shadow_live[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_count   = 0;
    shadow_cap     = lkvc_pkg::CAP_RESET;
    shadow_largest = lkvc_pkg::LARGEST_KEY_RESET;

    // Fresh cache, then the key limit at both extremes.
    add_typed(lkvc_pkg::KIND_GET, 14'd0, 32'sd0, 1'b0, 32'sd0, 1'b0);
    add_typed(lkvc_pkg::KIND_GET, 14'd16383, 32'sd0, 1'b0, 32'sd0, 1'b1);
    add_typed(lkvc_pkg::KIND_PUT, 14'd10001, 32'sd123, 1'b0, 32'sd0, 1'b1);
    add_typed(lkvc_pkg::KIND_PUT, 14'd10000, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 1'b0);
    add_typed(lkvc_pkg::KIND_GET, 14'd10000, 32'sd0, 1'b1, 32'sh7FFF_FFFF, 1'b0);
    add_typed(lkvc_pkg::KIND_PUT, 14'd0, 32'sh8000_0000, 1'b0, 32'sd0, 1'b0);
    add_typed(lkvc_pkg::KIND_GET, 14'd0, 32'sd0, 1'b1, 32'sh8000_0000, 1'b0);
    add_typed(lkvc_pkg::KIND_PUT, 14'd0, -32'sd1, 1'b1, 32'sd0, 1'b0);
    add_typed(lkvc_pkg::KIND_GET, 14'd0, 32'sd0, 1'b1, -32'sd1, 1'b0);
    add_write(lkvc_pkg::CFG_LARGEST_KEY, 14'd16383);
    add_req(lkvc_pkg::KIND_PUT, 14'd16383, 32'sh5555_5555);
    add_req(lkvc_pkg::KIND_GET, 14'd16383, 32'sd0);
    add_write(lkvc_pkg::CFG_LARGEST_KEY, 14'd0);
    add_typed(lkvc_pkg::KIND_GET, 14'd0, 32'sd0, 1'b1, -32'sd1, 1'b0);
    add_typed(lkvc_pkg::KIND_GET, 14'd1, 32'sd0, 1'b0, 32'sd0, 1'b1);
    add_typed(lkvc_pkg::KIND_PUT, 14'd3000, 32'sd1, 1'b0, 32'sd0, 1'b1);
    // A capacity of zero acts as one while three entries are still live.
    add_write(lkvc_pkg::CFG_LARGEST_KEY, 14'd16383);
    add_write(lkvc_pkg::CFG_CAPACITY, 14'd0);
    add_req(lkvc_pkg::KIND_PUT, 14'd3000, 32'shAAAA_AAAA);
    add_req(lkvc_pkg::KIND_GET, 14'd10000, 32'sd0);
    add_req(lkvc_pkg::KIND_PUT, 14'd5, 32'sd0);
    add_write(lkvc_pkg::CFG_CAPACITY, 14'd127);
    add_req(lkvc_pkg::KIND_PUT, 14'd6, 32'sd6);
    add_req(lkvc_pkg::KIND_GET, 14'd5, 32'sd0);
    add_req(lkvc_pkg::KIND_GET, 14'd3000, 32'sd0);
    add_write(lkvc_pkg::CFG_CAPACITY, 14'd1);
    add_req(lkvc_pkg::KIND_PUT, 14'd7, 32'sd7);
    add_req(lkvc_pkg::KIND_GET, 14'd6, 32'sd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_WRITE) begin
        drain_replies(SETTLE_CYCLES);
        write_reg(row.reg_index, row.reg_data);
      end else begin
        issue_request(row.kind, row.key, row.value, row.has_reply, row.reply);
      end
    end

    run_phase(340, 11, 7'd16, 14'd16383, 24);
    run_phase(330, 78, 7'd64, 14'd10000, 72);
    run_phase(330, 0, 7'd3, 14'd3000, 8);

    drain_replies(TAIL_CYCLES);

    $display("Ran %0d requests: %0d get hits, %0d get misses, %0d updates, %0d inserts",
             n_requests, n_get_hit, n_get_miss, n_put_update, n_put_insert);
    $display("with %0d evictions and %0d rejected keys over capacities 0..127",
             n_evict, n_rejected);
    $display("and key limits 0..16383");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
